/* hw/rtl/spvrwd_pkg.sv */
package spvrwd_pkg;

	// Opcodes of interest
	localparam logic [15:0] OPC_LOAD         = 16'd61;
	localparam logic [15:0] OPC_STORE        = 16'd62;
	localparam logic [15:0] OPC_ACCESS_CHAIN = 16'd65;
	localparam logic [15:0] OPC_IMAGE_WRITE  = 16'd99;
	localparam logic [15:0] OPC_ATOMIC_STORE = 16'd228;
	localparam logic [15:0] OPC_RMW_FIRST    = 16'd229;
	localparam logic [15:0] OPC_RMW_LAST     = 16'd242;
	localparam logic [15:0] OPC_ATOMIC_FADD  = 16'd6035;

	// Empty tracker marker
	localparam logic [31:0] ID_NONE = 32'hFFFF_FFFF;

	// Parameter positions within an instruction
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_LATER  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_VARIABLE_ID   = 1'b0;
	localparam logic CFG_WRITABLE_KIND = 1'b1;

	typedef struct packed {
		logic [31:0] module_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic resource_written;
		logic malformed;
	} out_item_t;

	function automatic logic is_atomic_rmw(input logic [15:0] op);
		return op inside {[OPC_RMW_FIRST:OPC_RMW_LAST], OPC_ATOMIC_FADD};
	endfunction

endpackage

/* hw/rtl/spvrwd_in_stage.sv */
module spvrwd_in_stage
	import spvrwd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     take,
	output logic     valid_s1,
	output in_item_t item_s1
);

	// Refill when empty or whenever the held request moves on
	assign in_ready = !valid_s1 || take;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* hw/rtl/spvrwd_core.sv */
module spvrwd_core
	import spvrwd_pkg::*;
#(
	parameter int HEADER_WORDS = 5
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  logic [31:0] variable_id,
	input  logic        writable_kind,
	output out_item_t   result
);

	logic [2:0]  hdr_q, hdr_n;
	logic [15:0] left_q, left_n;
	logic [15:0] op_q, op_n;
	logic [1:0]  pos_q, pos_n;
	logic [31:0] held_q, held_n;
	logic [31:0] chain_q, chain_n;
	logic [31:0] load_q, load_n;
	logic        found_q, found_n;
	logic        bad_q, bad_n;

	// Parse one word and work out the next tracker state
	always_comb begin
		logic [31:0] w;
		logic [15:0] cnt;
		w       = item.module_word;
		cnt     = w[31:16];
		hdr_n   = hdr_q;
		left_n  = left_q;
		op_n    = op_q;
		pos_n   = pos_q;
		held_n  = held_q;
		chain_n = chain_q;
		load_n  = load_q;
		found_n = found_q;
		bad_n   = bad_q;
		if (!found_q && !bad_q) begin
			if (hdr_q < 3'(HEADER_WORDS)) begin
				hdr_n = hdr_q + 3'd1;
			end else if (left_q == 16'd0) begin
				if (cnt == 16'd0) begin
					bad_n = 1'b1;
				end else begin
					op_n   = w[15:0];
					left_n = cnt - 16'd1;
					pos_n  = POS_FIRST;
				end
			end else begin
				left_n = left_q - 16'd1;
				if (pos_q != POS_LATER) begin
					pos_n = pos_q + 2'd1;
				end
				case (pos_q)
					POS_FIRST: begin
						if ((op_q == OPC_STORE || op_q == OPC_ATOMIC_STORE) && w == chain_q)
							found_n = 1'b1;
						if (op_q == OPC_IMAGE_WRITE && w == load_q)
							found_n = 1'b1;
					end
					POS_SECOND: begin
						if (op_q == OPC_ACCESS_CHAIN) begin
							if (w == chain_q) chain_n = ID_NONE;
							held_n = w;
						end
						if (op_q == OPC_LOAD) begin
							if (w == load_q) load_n = ID_NONE;
							held_n = w;
						end
					end
					POS_THIRD: begin
						if (op_q == OPC_ACCESS_CHAIN && w == variable_id)
							chain_n = held_q;
						if (op_q == OPC_LOAD && (w == variable_id || w == chain_q))
							load_n = held_q;
						if (is_atomic_rmw(op_q) && w == chain_q)
							found_n = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Report from the state after this word
	assign result.resource_written = found_n && writable_kind;
	assign result.malformed        = bad_n;

	// Advance state; return to reset after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= '0;
			left_q  <= '0;
			op_q    <= '0;
			pos_q   <= '0;
			held_q  <= '0;
			chain_q <= ID_NONE;
			load_q  <= ID_NONE;
			found_q <= 1'b0;
			bad_q   <= 1'b0;
		end else if (step) begin
			if (item.last_word) begin
				hdr_q   <= '0;
				left_q  <= '0;
				op_q    <= '0;
				pos_q   <= '0;
				held_q  <= '0;
				chain_q <= ID_NONE;
				load_q  <= ID_NONE;
				found_q <= 1'b0;
				bad_q   <= 1'b0;
			end else begin
				hdr_q   <= hdr_n;
				left_q  <= left_n;
				op_q    <= op_n;
				pos_q   <= pos_n;
				held_q  <= held_n;
				chain_q <= chain_n;
				load_q  <= load_n;
				found_q <= found_n;
				bad_q   <= bad_n;
			end
		end
	end

endmodule

/* hw/rtl/spirv_resource_write_detector.sv */
// A final word accepted passes from the input register to the result register,
// and waits in the input register while an earlier result is not yet taken.
// Throughput: one word per cycle; a waiting result only stalls a final word.
// Reset: arst_n clears the parser, trackers, configuration and both valid flags.
module spirv_resource_write_detector
	import spvrwd_pkg::*;
#(
	parameter int HEADER_WORDS = 5
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        take;
	logic        out_free;
	out_item_t   result;
	logic [31:0] variable_id_q;
	logic        writable_kind_q;
	logic        out_valid_q;
	out_item_t   out_item_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variable_id_q   <= '0;
			writable_kind_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VARIABLE_ID:   variable_id_q   <= cfg_data;
				CFG_WRITABLE_KIND: writable_kind_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	spvrwd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Move a word on unless it is final and the result slot is full
	assign out_free = !out_valid_q || out_ready;
	assign take     = valid_s1 && (!item_s1.last_word || out_free);

	spvrwd_core #(
		.HEADER_WORDS (HEADER_WORDS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (take),
		.item          (item_s1),
		.variable_id   (variable_id_q),
		.writable_kind (writable_kind_q),
		.result        (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item_s1.last_word) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last_word) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// A write and a malformed module never both show
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_item_q.resource_written && out_item_q.malformed))
		else $error("write and malformed reported together");

	// An empty input register always takes a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while empty");

	// A final word taken yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item_s1.last_word) |=> out_valid_q)
		else $error("result missing after final word");

	// A non-final word never waits on the output side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_s1.last_word) |-> take)
		else $error("non-final word stalled");

endmodule

/* tb/tb_spirv_resource_write_detector.sv */
`timescale 1ns / 1ps

module tb_spirv_resource_write_detector;
	import spvrwd_pkg::*;

	localparam int HDR_WORDS       = 5;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 140;
	localparam int HOLD_CYCLES     = 250;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = CFG_VARIABLE_ID;
	logic [31:0] cfg_data  = '0;

	// Shadow configuration and parser state of the detector
	logic [31:0] cfg_var_id = '0;
	logic        cfg_kind   = 1'b0;
	logic [2:0]  hdr_seen;
	logic [15:0] instr_left;
	logic [15:0] opcode;
	logic [1:0]  arg_pos;
	logic [31:0] held_id;
	logic [31:0] chain_id;
	logic [31:0] load_id;
	logic        wr_found;
	logic        mod_bad;

	in_item_t    word_q[$];
	out_item_t   verdict_q[$];
	logic [31:0] mod_buf[$];
	out_item_t   exp_res;

	int err_count   = 0;
	int examined    = 0;
	int n_queued    = 0;
	int n_modules   = 0;
	int n_written   = 0;
	int n_malformed = 0;
	int cycle_count = 0;
	int send_gap    = 0;
	int rx_gap      = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;
	bit hold_req    = 1'b0;
	bit idle_en     = 1'b1;

	spirv_resource_write_detector #(
		.HEADER_WORDS(HDR_WORDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Return the parser to its start-of-module state
	task automatic reset_parse();
		hdr_seen   = '0;
		instr_left = '0;
		opcode     = '0;
		arg_pos    = POS_FIRST;
		held_id    = '0;
		chain_id   = ID_NONE;
		load_id    = ID_NONE;
		wr_found   = 1'b0;
		mod_bad    = 1'b0;
	endtask

	function automatic logic rmw_op(input logic [15:0] op);
		return (op >= OPC_RMW_FIRST && op <= OPC_RMW_LAST) || op == OPC_ATOMIC_FADD;
	endfunction

	// Advance the shadow parser by one accepted word; queue a verdict on the last one
	task automatic predict_word(input in_item_t it);
		logic [31:0] w;
		logic [1:0]  pos;
		out_item_t   res;
		w = it.module_word;
		if (!wr_found && !mod_bad) begin
			examined++;
			if (hdr_seen < HDR_WORDS) begin
				hdr_seen++;
			end else if (instr_left == 16'd0) begin
				if (w[31:16] == 16'd0) begin
					mod_bad = 1'b1;
				end else begin
					opcode     = w[15:0];
					instr_left = w[31:16] - 16'd1;
					arg_pos    = POS_FIRST;
				end
			end else begin
				instr_left--;
				pos = arg_pos;
				if (arg_pos != POS_LATER)
					arg_pos++;
				case (pos)
					POS_FIRST: begin
						if ((opcode == OPC_STORE || opcode == OPC_ATOMIC_STORE) && w == chain_id)
							wr_found = 1'b1;
						if (opcode == OPC_IMAGE_WRITE && w == load_id)
							wr_found = 1'b1;
					end
					POS_SECOND: begin
						if (opcode == OPC_ACCESS_CHAIN) begin
							if (w == chain_id)
								chain_id = ID_NONE;
							held_id = w;
						end
						if (opcode == OPC_LOAD) begin
							if (w == load_id)
								load_id = ID_NONE;
							held_id = w;
						end
					end
					POS_THIRD: begin
						if (opcode == OPC_ACCESS_CHAIN && w == cfg_var_id)
							chain_id = held_id;
						if (opcode == OPC_LOAD && (w == cfg_var_id || w == chain_id))
							load_id = held_id;
						if (rmw_op(opcode) && w == chain_id)
							wr_found = 1'b1;
					end
					default: ;
				endcase
			end
		end
		if (it.last_word) begin
			res.resource_written = wr_found && cfg_kind;
			res.malformed        = mod_bad;
			verdict_q.push_back(res);
			n_modules++;
			if (res.resource_written)
				n_written++;
			if (res.malformed)
				n_malformed++;
			reset_parse();
		end
	endtask

	// Draw an id that often hits the variable, a tracked id or the empty marker
	function automatic logic [31:0] pick_id();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return cfg_var_id;
		if (r == 2)
			return ID_NONE;
		if (r == 3)
			return 32'd0;
		return 32'd100 + $urandom_range(0, 3);
	endfunction

	// Append one instruction, mostly well formed, to the module buffer
	task automatic add_instr();
		logic [31:0] args[$];
		logic [15:0] op;
		int unsigned kind;
		int unsigned r;
		int unsigned cnt;
		int unsigned emit_n;
		int          i;
		kind = $urandom_range(0, 31);
		if (kind == 0) begin
			// zero word count
			mod_buf.push_back({16'd0, 16'($urandom)});
			return;
		end
		if (kind == 1) begin
			// noise header with any count and opcode
			mod_buf.push_back($urandom);
			return;
		end
		if (kind < 8) begin
			op = OPC_ACCESS_CHAIN;
			args.push_back($urandom);
			args.push_back(pick_id());
			args.push_back(($urandom_range(0, 3) != 0) ? cfg_var_id : pick_id());
			repeat ($urandom_range(0, 2)) args.push_back($urandom_range(0, 7));
		end else if (kind < 13) begin
			op = OPC_LOAD;
			args.push_back($urandom);
			args.push_back(pick_id());
			r = $urandom_range(0, 5);
			if (r < 2)
				args.push_back(cfg_var_id);
			else if (r < 4)
				args.push_back(32'd100 + $urandom_range(0, 3));
			else
				args.push_back(pick_id());
		end else if (kind < 17) begin
			op = OPC_STORE;
			args.push_back(pick_id());
			args.push_back($urandom);
		end else if (kind < 20) begin
			op = OPC_IMAGE_WRITE;
			args.push_back(pick_id());
			args.push_back($urandom);
			args.push_back($urandom);
		end else if (kind < 22) begin
			op = OPC_ATOMIC_STORE;
			args.push_back(pick_id());
			repeat (3) args.push_back($urandom);
		end else if (kind < 26) begin
			r = $urandom_range(0, 5);
			if (r == 0)
				op = OPC_ATOMIC_FADD;
			else if (r == 1)
				op = OPC_RMW_LAST + 16'd1;
			else
				op = OPC_RMW_FIRST + 16'($urandom_range(0, OPC_RMW_LAST - OPC_RMW_FIRST));
			args.push_back($urandom);
			args.push_back(pick_id());
			args.push_back(pick_id());
			repeat (3) args.push_back($urandom);
		end else begin
			op = 16'($urandom);
			repeat ($urandom_range(0, 5)) args.push_back(($urandom_range(0, 1) == 0) ? pick_id() : $urandom);
		end
		// Vary the word count: truncate, pad, or overrun into the next words
		emit_n = args.size();
		cnt    = emit_n + 1;
		r      = $urandom_range(0, 15);
		if (r == 0) begin
			cnt    = $urandom_range(1, emit_n + 1);
			emit_n = cnt - 1;
		end else if (r == 1) begin
			repeat ($urandom_range(1, 3)) args.push_back($urandom);
			emit_n = args.size();
			cnt    = emit_n + 1;
		end else if (r == 2) begin
			cnt = emit_n + 1 + $urandom_range(1, 2);
		end
		mod_buf.push_back({16'(cnt), op});
		for (i = 0; i < int'(emit_n); i++)
			mod_buf.push_back(args[i]);
	endtask

	// Build one module and queue its words as requests
	task automatic gen_module(input bit short_mod);
		in_item_t    it;
		int unsigned hdr;
		int unsigned cut;
		int          i;
		mod_buf.delete();
		hdr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, HDR_WORDS - 1) : HDR_WORDS;
		repeat (hdr) mod_buf.push_back($urandom);
		if (hdr == HDR_WORDS)
			repeat (short_mod ? $urandom_range(0, 1) : $urandom_range(1, 14)) add_instr();
		if ($urandom_range(0, 7) == 0 && mod_buf.size() > 1) begin
			cut = $urandom_range(1, mod_buf.size() - 1);
			while (mod_buf.size() > cut)
				void'(mod_buf.pop_back());
		end
		if (mod_buf.size() == 0)
			mod_buf.push_back($urandom);
		for (i = 0; i < mod_buf.size(); i++) begin
			it.module_word = mod_buf[i];
			it.last_word   = (i == mod_buf.size() - 1);
			word_q.push_back(it);
		end
		n_queued += int'(mod_buf.size());
	endtask

	task automatic push_word(input logic [31:0] w, input logic last);
		in_item_t it;
		it.module_word = w;
		it.last_word   = last;
		word_q.push_back(it);
	endtask

	task automatic write_cfg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_VARIABLE_ID)
			cfg_var_id = val;
		else
			cfg_kind = val[0];
	endtask

	// Wait until every request is sent and every verdict has come back
	task automatic wait_drained();
		@(negedge clk);
		while (word_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Driver: predict on acceptance, then offer the next pending request
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_word(in_item);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (word_q.size() > 0) begin
					in_item  <= word_q.pop_front();
					in_valid <= 1'b1;
					if (idle_en && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each verdict with the oldest one predicted, then pace out_ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t ns: verdict with none expected: expected nothing, actual %b/%b",
						$time, out_item.resource_written, out_item.malformed);
					err_count++;
				end else begin
					exp_res = verdict_q.pop_front();
					if (out_item.resource_written !== exp_res.resource_written) begin
						$display("%0t ns: resource_written mismatch: expected %b, actual %b",
							$time, exp_res.resource_written, out_item.resource_written);
						err_count++;
					end
					if (out_item.malformed !== exp_res.malformed) begin
						$display("%0t ns: malformed mismatch: expected %b, actual %b",
							$time, exp_res.malformed, out_item.malformed);
						err_count++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int          p;
		int          target;
		logic [31:0] var_sel;
		reset_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed modules
		write_cfg(CFG_VARIABLE_ID, 32'd7);
		write_cfg(CFG_WRITABLE_KIND, {31'h7FFF_FFFF, 1'b1});
		// module that ends inside its header
		push_word(32'hFFFF_FFFF, 1'b1);
		// chain on the variable, then a store through it
		push_word(32'h0723_0203, 1'b0);
		push_word(32'h0001_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word({16'd4, OPC_ACCESS_CHAIN}, 1'b0);
		push_word(32'd1, 1'b0);
		push_word(32'd20, 1'b0);
		push_word(32'd7, 1'b0);
		push_word({16'd3, OPC_STORE}, 1'b0);
		push_word(32'd20, 1'b0);
		push_word(32'd9, 1'b1);
		// store through the empty marker, then a zero count that must be ignored
		push_word(32'h0723_0203, 1'b0);
		push_word(32'h0001_0500, 1'b0);
		push_word(32'h0008_0001, 1'b0);
		push_word(32'h0000_0040, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word({16'd2, OPC_STORE}, 1'b0);
		push_word(ID_NONE, 1'b0);
		push_word(32'h0000_0000, 1'b1);
		// zero word count on the first instruction
		push_word(32'h0723_0203, 1'b0);
		push_word(32'h0001_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h0000_0010, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word({16'd0, OPC_LOAD}, 1'b1);
		wait_drained();

		// Random phases, each under its own configuration
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       var_sel = 32'd0;
				1:       var_sel = ID_NONE;
				2:       var_sel = 32'd100;
				4:       var_sel = 32'd1;
				6:       var_sel = 32'h8000_0000;
				7:       var_sel = 32'd102;
				default: var_sel = $urandom;
			endcase
			write_cfg(CFG_VARIABLE_ID, var_sel);
			write_cfg(CFG_WRITABLE_KIND,
				{31'($urandom), (p == 1 || p == 4) ? 1'b0 : 1'b1});
			idle_en = (p != PHASES - 1);
			if (p == 2)
				hold_req <= 1'b1;
			target = n_queued + WORDS_PER_PHASE;
			while (n_queued < target) begin
				if (word_q.size() < 8)
					gen_module(p == 2);
				@(negedge clk);
			end
			wait_drained();
		end

		$display("Checked %0d modules (%0d written, %0d malformed) over %0d parsed words",
			n_modules, n_written, n_malformed, examined);
		$display("under %0d configurations, with random gaps and one long output stall.",
			PHASES + 1);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
